// ===== hdl/lcb_pkg.sv =====
// Shared constants, coefficients and helper functions of the luma tone-curve pixel core.
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

  // Default configuration of the curve set.
  localparam int CURVES_PER_SIDE_DEF = 3;
  localparam int FRAC_BITS_DEF       = 8;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int LEVEL_W   = 11;
  localparam int SEL_W     = 3;
  localparam int ENTRIES   = 256;

  // Transaction commands.
  localparam logic CMD_PIXEL       = 1'b0;
  localparam logic CMD_TABLE_WRITE = 1'b1;

  // Q14 arithmetic.
  localparam int Q14_SHIFT = 14;
  localparam int Q14_HALF  = 8192;
  localparam int YSUM_W    = 23;
  localparam int PROD_W    = 25;
  localparam int DESC_W    = PROD_W - Q14_SHIFT;
  localparam int SAT_W     = 12;
  localparam int DIFF_W    = 9;

  // BT.601 forward luma weights.
  localparam int Y_COEF_R = 4899;
  localparam int Y_COEF_G = 9617;
  localparam int Y_COEF_B = 1868;

  // Chroma weights, forward and inverse.
  localparam logic signed [PROD_W-1:0] U_COEF     = 25'sd8061;
  localparam logic signed [PROD_W-1:0] V_COEF     = 25'sd14369;
  localparam logic signed [PROD_W-1:0] UV_OFFSET  = 25'sd2097152;
  localparam logic signed [PROD_W-1:0] B_COEF_U   = 25'sd33292;
  localparam logic signed [PROD_W-1:0] G_COEF_U   = 25'sd6472;
  localparam logic signed [PROD_W-1:0] G_COEF_V   = 25'sd9519;
  localparam logic signed [PROD_W-1:0] R_COEF_V   = 25'sd18678;
  localparam logic signed [PROD_W-1:0] DESC_ROUND = 25'sd8192;
  localparam logic signed [DIFF_W-1:0] CHROMA_MID = 9'sd128;
  localparam logic signed [SAT_W-1:0]  PIX_MAX_S  = 12'sd255;

  // Rounded Q14 descale: floor((x + 8192) / 16384).
  function automatic logic signed [DESC_W-1:0] desc_q14(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] t;
    t = x + DESC_ROUND;
    return DESC_W'(t >>> Q14_SHIFT);
  endfunction

  // Saturate a signed value to the 8-bit pixel range.
  function automatic logic [PIX_W-1:0] sat8(input logic signed [SAT_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > PIX_MAX_S) begin
      r = '1;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/luma_curve_brightness_pixel_core.sv =====
// Top level of the luma tone-curve brightness core: six-stage pixel pipeline and curve memory.
`timescale 1ns / 1ps
`default_nettype none

// Takes one BGR pixel per clock unless the pipeline stalls, returning the edited pixel from
// stage 6, at a sustained rate of one pixel per cycle; the curve memory reads both
// neighboring curves in the same cycle through two read ports, which sets that rate.
// Table-write transactions travel the first two stages and update the curve memory in
// order with the pixels around them; they produce no output transaction. Curve entries
// hold no reset value: every entry a pixel can select must be written before use.
// Output-side stalls are absorbed by empty stages, so the input takes transactions until the
// pipeline is full. Brightness must be written only while idle; the block does not check it.
module luma_curve_brightness_pixel_core
  import lcb_pkg::*;
#(
  parameter int CURVES_PER_SIDE = CURVES_PER_SIDE_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LEVEL_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [PIX_W-1:0]   blue_in_i,
  input  wire logic [PIX_W-1:0]   green_in_i,
  input  wire logic [PIX_W-1:0]   red_in_i,
  input  wire logic [SEL_W-1:0]   curve_select_i,
  input  wire logic [PIX_W-1:0]   entry_index_i,
  input  wire logic [PIX_W-1:0]   table_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [PIX_W-1:0]        blue_out_o,
  output logic [PIX_W-1:0]        green_out_o,
  output logic [PIX_W-1:0]        red_out_o
);

  localparam int NUM_TABLES = 2 * CURVES_PER_SIDE;
  localparam int ONE_FRAC   = 1 << FRAC_BITS;
  localparam int LEVEL_MAX  = CURVES_PER_SIDE * ONE_FRAC;
  localparam int TBL_W      = $clog2(NUM_TABLES);
  localparam int ADDR_W     = TBL_W + PIX_W;
  localparam int MEM_DEPTH  = NUM_TABLES * ENTRIES;
  localparam int SEG_W      = $clog2(NUM_TABLES + 1);
  localparam int FW         = FRAC_BITS + 1;
  localparam int LVL_W      = (FRAC_BITS + 5 > LEVEL_W + 1) ? FRAC_BITS + 5 : LEVEL_W + 1;
  localparam int BLEND_W    = PIX_W + FRAC_BITS + 1;
  localparam logic signed [LVL_W-1:0] LEVEL_MAX_S = LVL_W'(LEVEL_MAX);

  // Maps a curve level index to its table; the identity level has no table.
  function automatic logic [TBL_W-1:0] tbl_of(input logic [SEG_W-1:0] c);
    logic [TBL_W-1:0] t;
    if (c > SEG_W'(CURVES_PER_SIDE)) begin
      t = TBL_W'(c - SEG_W'(1));
    end else begin
      t = TBL_W'(c);
    end
    return t;
  endfunction

  // Brightness register.
  logic signed [LEVEL_W-1:0] brightness_q;

  // Stage valid bits and load enables.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  // Stage 1: luma sum.
  logic              s1_cmd_q;
  logic [PIX_W-1:0]  s1_blue_q, s1_red_q, s1_idx_q, s1_val_q;
  logic [SEL_W-1:0]  s1_sel_q;
  logic [YSUM_W-1:0] s1_ysum_q, s1_ysum_d;

  // Stage 2: luma.
  logic             s2_cmd_q;
  logic [PIX_W-1:0] s2_blue_q, s2_red_q, s2_idx_q, s2_val_q;
  logic [SEL_W-1:0] s2_sel_q;
  logic [PIX_W-1:0] s2_luma_q, s2_luma_d;

  // Stage 3: chroma products and curve reads.
  logic signed [PROD_W-1:0] s3_pu_q, s3_pu_d, s3_pv_q, s3_pv_d;
  logic [PIX_W-1:0]         s3_luma_q, s3_rda_q, s3_rdb_q;
  logic                     s3_ida_q, s3_idb_q;
  logic [FW-1:0]            s3_frac_q;

  // Stage 4: chroma offsets and blend sum.
  logic signed [DIFF_W-1:0] s4_du_q, s4_du_d, s4_dv_q, s4_dv_d;
  logic [BLEND_W-1:0]       s4_blend_q, s4_blend_d;

  // Stage 5: edited luma and inverse chroma terms.
  logic [PIX_W-1:0]         s5_luma_q, s5_luma_d;
  logic signed [PROD_W-1:0] s5_cb_q, s5_cb_d, s5_cg_q, s5_cg_d, s5_cr_q, s5_cr_d;

  // Stage 6: output register.
  logic [PIX_W-1:0] s6_blue_q, s6_blue_d, s6_green_q, s6_green_d, s6_red_q, s6_red_d;

  // Curve selection from the brightness register.
  logic signed [LVL_W-1:0] lvl_ext, lvl_clamp, lvl_shift;
  logic [SEG_W-1:0]        seg_raw, seg_a, seg_b;
  logic [FW-1:0]           frac_raw, frac_sel;

  // Curve memory.
  logic [PIX_W-1:0]  curve_mem [MEM_DEPTH];
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic              mem_we;

  // Each stage loads when it is empty or its content moves on.
  assign ld6        = !s6_valid_q || out_ready_i;
  assign ld5        = !s5_valid_q || ld6;
  assign ld4        = !s4_valid_q || ld5;
  assign ld3        = !s3_valid_q || ld4;
  assign ld2        = !s2_valid_q || ld3;
  assign ld1        = !s1_valid_q || ld2;
  assign in_ready_o = ld1;

  // Valid bits and the brightness register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      s5_valid_q   <= 1'b0;
      s6_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        brightness_q <= cfg_wdata_i;
      end
      if (ld1) begin
        s1_valid_q <= in_valid_i;
      end
      if (ld2) begin
        s2_valid_q <= s1_valid_q;
      end
      // Table writes retire when they leave stage 2.
      if (ld3) begin
        s3_valid_q <= s2_valid_q && (s2_cmd_q == CMD_PIXEL);
      end
      if (ld4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (ld5) begin
        s5_valid_q <= s4_valid_q;
      end
      if (ld6) begin
        s6_valid_q <= s5_valid_q;
      end
    end
  end

  // Clamp the level and split it into segment and blend fraction.
  always_comb begin
    lvl_ext = LVL_W'(brightness_q);
    if (lvl_ext > LEVEL_MAX_S) begin
      lvl_clamp = LEVEL_MAX_S;
    end else if (lvl_ext < -LEVEL_MAX_S) begin
      lvl_clamp = -LEVEL_MAX_S;
    end else begin
      lvl_clamp = lvl_ext;
    end
    lvl_shift = lvl_clamp + LEVEL_MAX_S;
    seg_raw   = SEG_W'(lvl_shift >>> FRAC_BITS);
    frac_raw  = FW'(lvl_shift[FRAC_BITS-1:0]);
    // The top level uses the last curve in full.
    if (seg_raw >= SEG_W'(NUM_TABLES)) begin
      seg_a    = SEG_W'(NUM_TABLES - 1);
      frac_sel = FW'(ONE_FRAC);
    end else begin
      seg_a    = seg_raw;
      frac_sel = frac_raw;
    end
    seg_b = seg_a + SEG_W'(1);
  end

  // Stage 1 logic: weighted luma sum.
  always_comb begin
    s1_ysum_d = YSUM_W'(red_in_i) * YSUM_W'(Y_COEF_R)
              + YSUM_W'(green_in_i) * YSUM_W'(Y_COEF_G)
              + YSUM_W'(blue_in_i) * YSUM_W'(Y_COEF_B);
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_cmd_q  <= command_i;
      s1_blue_q <= blue_in_i;
      s1_red_q  <= red_in_i;
      s1_sel_q  <= curve_select_i;
      s1_idx_q  <= entry_index_i;
      s1_val_q  <= table_value_i;
      s1_ysum_q <= s1_ysum_d;
    end
  end

  // Stage 2 logic: rounded luma, which never exceeds 255.
  assign s2_luma_d = PIX_W'((s1_ysum_q + YSUM_W'(Q14_HALF)) >> Q14_SHIFT);

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_blue_q <= s1_blue_q;
      s2_red_q  <= s1_red_q;
      s2_sel_q  <= s1_sel_q;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_luma_q <= s2_luma_d;
    end
  end

  // Stage 3 logic: color differences times forward chroma weights.
  always_comb begin
    logic signed [DIFF_W-1:0] bdiff, rdiff;
    bdiff   = $signed({1'b0, s2_blue_q}) - $signed({1'b0, s2_luma_q});
    rdiff   = $signed({1'b0, s2_red_q}) - $signed({1'b0, s2_luma_q});
    s3_pu_d = PROD_W'(bdiff) * U_COEF;
    s3_pv_d = PROD_W'(rdiff) * V_COEF;
  end

  // Curve memory ports; writes take effect in transaction order at the read stage.
  assign rd_addr_a = {tbl_of(seg_a), s2_luma_q};
  assign rd_addr_b = {tbl_of(seg_b), s2_luma_q};
  assign wr_addr   = {TBL_W'(s2_sel_q), s2_idx_q};
  assign mem_we    = ld3 && s2_valid_q && (s2_cmd_q == CMD_TABLE_WRITE)
                     && ({1'b0, s2_sel_q} < 4'(NUM_TABLES));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      curve_mem[wr_addr] <= s2_val_q;
    end
    if (ld3) begin
      s3_rda_q <= curve_mem[rd_addr_a];
      s3_rdb_q <= curve_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_pu_q   <= s3_pu_d;
      s3_pv_q   <= s3_pv_d;
      s3_luma_q <= s2_luma_q;
      s3_ida_q  <= (seg_a == SEG_W'(CURVES_PER_SIDE));
      s3_idb_q  <= (seg_b == SEG_W'(CURVES_PER_SIDE));
      s3_frac_q <= frac_sel;
    end
  end

  // Stage 4 logic: saturated chroma minus its midpoint, and the curve blend.
  always_comb begin
    logic [PIX_W-1:0] u_sat, v_sat, ya, yb;
    u_sat      = sat8(SAT_W'(desc_q14(s3_pu_q + UV_OFFSET)));
    v_sat      = sat8(SAT_W'(desc_q14(s3_pv_q + UV_OFFSET)));
    s4_du_d    = $signed({1'b0, u_sat}) - CHROMA_MID;
    s4_dv_d    = $signed({1'b0, v_sat}) - CHROMA_MID;
    ya         = s3_ida_q ? s3_luma_q : s3_rda_q;
    yb         = s3_idb_q ? s3_luma_q : s3_rdb_q;
    s4_blend_d = BLEND_W'(ya) * BLEND_W'(FW'(ONE_FRAC) - s3_frac_q)
               + BLEND_W'(yb) * BLEND_W'(s3_frac_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s4_du_q    <= s4_du_d;
      s4_dv_q    <= s4_dv_d;
      s4_blend_q <= s4_blend_d;
    end
  end

  // Stage 5 logic: rounded edited luma and inverse chroma terms.
  always_comb begin
    s5_luma_d = PIX_W'((s4_blend_q + BLEND_W'(ONE_FRAC / 2)) >> FRAC_BITS);
    s5_cb_d   = PROD_W'(s4_du_q) * B_COEF_U;
    s5_cg_d   = PROD_W'(s4_du_q) * G_COEF_U + PROD_W'(s4_dv_q) * G_COEF_V;
    s5_cr_d   = PROD_W'(s4_dv_q) * R_COEF_V;
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      s5_luma_q <= s5_luma_d;
      s5_cb_q   <= s5_cb_d;
      s5_cg_q   <= s5_cg_d;
      s5_cr_q   <= s5_cr_d;
    end
  end

  // Stage 6 logic: back to BGR with saturation.
  always_comb begin
    logic signed [SAT_W-1:0] luma_s;
    luma_s     = $signed(SAT_W'(s5_luma_q));
    s6_blue_d  = sat8(luma_s + SAT_W'(desc_q14(s5_cb_q)));
    s6_green_d = sat8(luma_s - SAT_W'(desc_q14(s5_cg_q)));
    s6_red_d   = sat8(luma_s + SAT_W'(desc_q14(s5_cr_q)));
  end

  always_ff @(posedge clk_i) begin
    if (ld6) begin
      s6_blue_q  <= s6_blue_d;
      s6_green_q <= s6_green_d;
      s6_red_q   <= s6_red_d;
    end
  end

  assign out_valid_o = s6_valid_q;
  assign blue_out_o  = s6_blue_q;
  assign green_out_o = s6_green_q;
  assign red_out_o   = s6_red_q;

  // An empty output register means nothing can block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // A result only appears after stage 5 held a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s5_valid_q))
    else $error("output became valid without a pixel in stage 5");

  // The selected segment and fraction stay within the curve set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_a < SEG_W'(NUM_TABLES)) && (frac_sel <= FW'(ONE_FRAC)))
    else $error("curve segment or blend fraction out of range");

  // A table write leaving stage 2 never occupies stage 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && s2_valid_q && (s2_cmd_q == CMD_TABLE_WRITE)) |=> !s3_valid_q)
    else $error("table write transaction passed the memory stage");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench of the luma tone-curve brightness pixel core.
`timescale 1ns / 1ps

module testbench;
  import lcb_pkg::*;

  // Curve set and fixed-point layout of the block under test.
  localparam int CPS         = CURVES_PER_SIDE_DEF;
  localparam int FB          = FRAC_BITS_DEF;
  localparam int NUM_CURVES  = 2 * CPS;
  localparam int ONE_FRAC    = 1 << FB;
  localparam int LEVEL_LIMIT = CPS * ONE_FRAC;

  // Conversion weights in Q14.
  localparam int Y_R_W       = 4899;
  localparam int Y_G_W       = 9617;
  localparam int Y_B_W       = 1868;
  localparam int U_W         = 8061;
  localparam int V_W         = 14369;
  localparam int B_U_W       = 33292;
  localparam int G_U_W       = 6472;
  localparam int G_V_W       = 9519;
  localparam int R_V_W       = 18678;
  localparam int CHROMA_MID  = 128;
  localparam int CHROMA_BIAS = CHROMA_MID * 16384;

  // Bench timing.
  localparam int CLK_HALF        = 6;
  localparam int DRAIN_PAD       = 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_LIMIT    = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 620;
  localparam int LEVEL_PERIOD    = 130;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // Block ports.
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [LEVEL_W-1:0] cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic               command      = CMD_PIXEL;
  logic [PIX_W-1:0]   blue_in      = '0;
  logic [PIX_W-1:0]   green_in     = '0;
  logic [PIX_W-1:0]   red_in       = '0;
  logic [SEL_W-1:0]   curve_select = '0;
  logic [PIX_W-1:0]   entry_index  = '0;
  logic [PIX_W-1:0]   table_value  = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [PIX_W-1:0]   blue_out;
  logic [PIX_W-1:0]   green_out;
  logic [PIX_W-1:0]   red_out;

  // Predictor state: brightness and the curve tables with their written flags.
  int         bright_level = 0;
  logic [7:0] curve_mem     [NUM_CURVES*ENTRIES];
  bit         curve_written [NUM_CURVES*ENTRIES];

  pixel_t expected_pixels[$];
  int     error_count     = 0;
  int     send_idle_pct   = 0;
  int     recv_idle_pct   = 0;
  int     hold_off        = 0;
  int     idle_cycles     = 0;
  int     items_sent      = 0;

  int special_levels[16] = '{-1024, -769, -768, -767, -513, -256, -1, 0,
                             1, 255, 256, 511, 767, 768, 769, 1023};

  luma_curve_brightness_pixel_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .blue_in_i      (blue_in),
    .green_in_i     (green_in),
    .red_in_i       (red_in),
    .curve_select_i (curve_select),
    .entry_index_i  (entry_index),
    .table_value_i  (table_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .blue_out_o     (blue_out),
    .green_out_o    (green_out),
    .red_out_o      (red_out)
  );

  // Free-running clock.
  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Rounded Q14 descale, floor((x + 8192) / 16384).
  function automatic int q14_round(input int x);
    return (x + 8192) >>> 14;
  endfunction

  function automatic int clamp8(input int v);
    if (v < 0) begin
      return 0;
    end else if (v > 255) begin
      return 255;
    end
    return v;
  endfunction

  function automatic int luma_of(input int b, input int g, input int r);
    return clamp8(q14_round(Y_R_W * r + Y_G_W * g + Y_B_W * b));
  endfunction

  // Lower curve of the blend and the weight of the upper one.
  function automatic void curve_pair(output int seg, output int frac);
    int lvl;
    lvl = bright_level;
    if (lvl < -LEVEL_LIMIT) begin
      lvl = -LEVEL_LIMIT;
    end
    if (lvl > LEVEL_LIMIT) begin
      lvl = LEVEL_LIMIT;
    end
    lvl  = lvl + LEVEL_LIMIT;
    seg  = lvl >> FB;
    frac = lvl & (ONE_FRAC - 1);
    // The top level uses the last curve in full.
    if (seg >= NUM_CURVES) begin
      seg  = NUM_CURVES - 1;
      frac = ONE_FRAC;
    end
  endfunction

  // Stored table that holds a curve level other than the identity.
  function automatic int curve_table_of(input int c);
    return (c > CPS) ? c - 1 : c;
  endfunction

  function automatic int curve_value(input int c, input int y);
    if (c == CPS) begin
      return y;
    end
    return curve_mem[curve_table_of(c) * ENTRIES + y];
  endfunction

  // Edited pixel for the present brightness and curve tables.
  function automatic pixel_t edit_pixel(input int b, input int g, input int r);
    int     y, u, v, seg, frac, ya, yb, ye;
    pixel_t p;
    y = luma_of(b, g, r);
    u = clamp8(q14_round((b - y) * U_W + CHROMA_BIAS));
    v = clamp8(q14_round((r - y) * V_W + CHROMA_BIAS));
    curve_pair(seg, frac);
    ya = curve_value(seg, y);
    yb = curve_value(seg + 1, y);
    ye = clamp8((ya * (ONE_FRAC - frac) + yb * frac + ONE_FRAC / 2) >>> FB);
    p.blue  = PIX_W'(clamp8(ye + q14_round((u - CHROMA_MID) * B_U_W)));
    p.green = PIX_W'(clamp8(ye - q14_round((u - CHROMA_MID) * G_U_W
                                           + (v - CHROMA_MID) * G_V_W)));
    p.red   = PIX_W'(clamp8(ye + q14_round((v - CHROMA_MID) * R_V_W)));
    return p;
  endfunction

  function automatic int pick_channel();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return 0;
    end else if (r < 30) begin
      return 255;
    end
    return $urandom_range(255);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    if ($urandom_range(1) == 0) begin
      return LEVEL_W'(special_levels[$urandom_range(15)]);
    end
    return LEVEL_W'($urandom_range(2047));
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  // Offers one transaction and updates the prediction once it is accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_item(input logic cmd, input int b, input int g, input int r,
                           input int sel, input int idx, input int val);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    blue_in      <= PIX_W'(b);
    green_in     <= PIX_W'(g);
    red_in       <= PIX_W'(r);
    curve_select <= SEL_W'(sel);
    entry_index  <= PIX_W'(idx);
    table_value  <= PIX_W'(val);
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
    if (cmd == CMD_TABLE_WRITE) begin
      // Writes to a select past the last table are ignored.
      if (sel < NUM_CURVES) begin
        curve_mem[sel * ENTRIES + idx]     = 8'(val);
        curve_written[sel * ENTRIES + idx] = 1'b1;
      end
    end else begin
      expected_pixels.push_back(edit_pixel(b, g, r));
    end
    @(negedge clk);
  endtask

  // Sends a pixel, first loading any curve entry that it would read unwritten.
  task automatic send_pixel(input int b, input int g, input int r);
    int y, seg, frac, c, t;
    y = luma_of(b, g, r);
    curve_pair(seg, frac);
    for (c = seg; c <= seg + 1; c++) begin
      if (c != CPS) begin
        t = curve_table_of(c);
        if (!curve_written[t * ENTRIES + y]) begin
          send_item(CMD_TABLE_WRITE, $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), t, y, $urandom_range(255));
        end
      end
    end
    send_item(CMD_PIXEL, b, g, r, $urandom_range(7), $urandom_range(255),
              $urandom_range(255));
  endtask

  // Stops offering and waits until every predicted pixel has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic set_brightness(input logic [LEVEL_W-1:0] raw);
    cfg_we       <= 1'b1;
    cfg_wdata    <= raw;
    bright_level = int'($signed(raw));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset brightness: the identity curve in full, with the first upper curve at zero weight.
  task automatic test_identity_pixels();
    send_idle_pct = 21;
    recv_idle_pct = 88;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 0, 255);
    wait_for_results();
  endtask

  // Table writes at the corner entries, and writes to invalid selects.
  task automatic test_table_write_edges();
    send_item(CMD_TABLE_WRITE, 255, 255, 255, 0, 0, 0);
    send_item(CMD_TABLE_WRITE, 0, 0, 0, NUM_CURVES - 1, 255, 255);
    send_item(CMD_TABLE_WRITE, 0, 255, 0, 6, 0, 255);
    send_item(CMD_TABLE_WRITE, 255, 0, 255, 7, 255, 0);
    wait_for_results();
  endtask

  // Lowest and top levels, clamped values and the level just below zero.
  task automatic test_brightness_extremes();
    int levels[5] = '{-768, 768, 1023, -1024, -1};
    foreach (levels[k]) begin
      set_brightness(LEVEL_W'(levels[k]));
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      wait_for_results();
    end
  endtask

  // Long output stall while the sender keeps offering, then a burst with no idling on either side.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_brightness(LEVEL_W'(-300));
    @(posedge clk);
    hold_off = HOLD_OFF_CYCLES;
    @(negedge clk);
    repeat (40) send_pixel(pick_channel(), pick_channel(), pick_channel());
    wait_for_results();
    repeat (10) send_pixel(pick_channel(), pick_channel(), pick_channel());
    wait_for_results();
  endtask

  // Mixed pixel and table traffic under one pair of idle rates.
  task automatic run_traffic_phase(input int s_pct, input int r_pct);
    int r, v, target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target        = items_sent + PHASE_ITEMS;
    for (int k = 0; items_sent < target; k++) begin
      if (k % LEVEL_PERIOD == 0) begin
        wait_for_results();
        set_brightness(pick_level());
      end
      r = $urandom_range(99);
      if (r < 70) begin
        send_pixel(pick_channel(), pick_channel(), pick_channel());
      end else if (r < 78) begin
        // Gray pixels keep the chroma at its midpoint.
        v = $urandom_range(255);
        send_pixel(v, v, v);
      end else if (r < 93) begin
        send_item(CMD_TABLE_WRITE, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(NUM_CURVES - 1),
                  $urandom_range(255), $urandom_range(255));
      end else begin
        send_item(CMD_TABLE_WRITE, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(7, NUM_CURVES),
                  $urandom_range(255), $urandom_range(255));
      end
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(21, 88);
    run_traffic_phase(88, 21);
    run_traffic_phase(0, 0);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off  = hold_off - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each output transaction with the oldest predicted pixel.
  always @(posedge clk) begin : check_output
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected output b=%0d g=%0d r=%0d",
                               blue_out, green_out, red_out));
      end else begin
        want = expected_pixels.pop_front();
        if (blue_out !== want.blue || green_out !== want.green ||
            red_out !== want.red) begin
          note_failure($sformatf("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 want.blue, want.green, want.red,
                                 blue_out, green_out, red_out));
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_identity_pixels();
    test_table_write_edges();
    test_brightness_extremes();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    if (expected_pixels.size() != 0) begin
      note_failure($sformatf("%0d predicted pixels never arrived",
                             expected_pixels.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
